FILE: hw/rtl/epm_pkg.sv
// Shared constants and types for the entropy pool mixer.
package epm_pkg;

    localparam int DATA_W             = 64;
    localparam int OUT_W              = 32;
    localparam int OFFSET_W           = 7;
    localparam int OFFSET_REDUCE_MAX  = 8;
    localparam int DEF_POOL_WORDS     = 128;
    localparam int DEF_WALK_STEPS     = 256;
    localparam int FOLD_ROT           = 17;
    localparam int FIN_SHL_A          = 13;
    localparam int FIN_SHR            = 7;
    localparam int FIN_SHL_B          = 17;

    typedef logic [DATA_W-1:0] word_t;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_WALK  = 5'b00100,
        ST_FOLD  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

endpackage

FILE: hw/rtl/entropy_pool_mixer.sv
// Top level of the entropy pool mixer: walk sequencer, fold, finalizer and stream ports.
// A request is taken only in idle, and the next one not before its result is loaded
// into the output register. The walk issues one pool read-modify-write per cycle through
// the single read port, forwarding back-to-back hits.
// Reset: rst_n clears control state, accumulator and position; the pool is then zeroed
// by a sweep over every word during which no request is taken.
module entropy_pool_mixer #(
    parameter int POOL_WORDS = epm_pkg::DEF_POOL_WORDS,
    parameter int WALK_STEPS = epm_pkg::DEF_WALK_STEPS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [epm_pkg::DATA_W-1:0]     s_tdata,   // [63:0] jitter_sample
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [epm_pkg::OUT_W-1:0]      m_tdata    // [31:0] random_word
);
    import epm_pkg::*;

    localparam int IDX_W  = $clog2(POOL_WORDS);
    localparam int SUM_W  = ((IDX_W > OFFSET_W) ? IDX_W : OFFSET_W) + 1;
    localparam int STEP_W = (WALK_STEPS > 1) ? $clog2(WALK_STEPS) : 1;

    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(POOL_WORDS - 1);
    localparam logic [SUM_W-1:0]  POOL_SUM  = SUM_W'(POOL_WORDS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WALK_STEPS - 1);

    state_t            state_reg, state_next;
    word_t             acc_reg, acc_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    word_t             sample_reg, sample_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic              fwd_valid_reg, fwd_valid_next;
    word_t             fwd_data_reg, fwd_data_next;
    logic [OUT_W-1:0]  fin_reg, fin_next;
    logic [OUT_W-1:0]  out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    word_t             mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    word_t             mem_rdata;

    word_t             rd_word;
    word_t             walk_word;
    word_t             walk_acc;
    logic [IDX_W-1:0]  pos_inc;
    word_t             fold_acc;
    word_t             fin_word;
    logic [IDX_W-1:0]  base_pos;
    logic [OFFSET_W-1:0] base_off;
    logic [SUM_W-1:0]  off_mod;
    logic [SUM_W-1:0]  slot_sum;
    logic [IDX_W-1:0]  slot_calc;

    epm_pool_ram #(
        .DEPTH (POOL_WORDS)
    ) u_pool (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_word   = fwd_valid_reg ? fwd_data_reg : mem_rdata;
    assign walk_word = {rd_word[DATA_W-2:0] ^ acc_reg[DATA_W-2:0],
                        rd_word[DATA_W-1] ^ acc_reg[DATA_W-1]};
    assign walk_acc  = acc_reg + walk_word;
    assign pos_inc   = (pos_reg == LAST_IDX) ? '0 : pos_reg + 1'b1;
    assign fold_acc  = acc_reg ^ sample_reg
                     ^ {sample_reg[DATA_W-FOLD_ROT-1:0], sample_reg[DATA_W-1:DATA_W-FOLD_ROT]};

    always_comb
    begin
        word_t w;
        w = fold_acc;
        w = w ^ (w << FIN_SHL_A);
        w = w ^ (w >> FIN_SHR);
        w = w ^ (w << FIN_SHL_B);
        fin_word = w;
    end

    // Slot selection: offset reduced (OFFSET_REDUCE_MAX tries), then one wrap of the sum.
    assign base_pos = (state_reg == ST_IDLE) ? pos_reg : pos_inc;
    assign base_off = (state_reg == ST_IDLE) ? acc_reg[OFFSET_W-1:0] : walk_acc[OFFSET_W-1:0];

    always_comb
    begin
        logic [SUM_W-1:0] r;
        r = SUM_W'(base_off);
        for (int k = 0; k < OFFSET_REDUCE_MAX; k++)
        begin
            if (r >= POOL_SUM)
            begin
                r = r - POOL_SUM;
            end
        end
        off_mod = r;
    end

    always_comb
    begin
        slot_sum = SUM_W'(base_pos) + off_mod;
        if (slot_sum >= POOL_SUM)
        begin
            slot_sum = slot_sum - POOL_SUM;
        end
        slot_calc = slot_sum[IDX_W-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        sample_next    = sample_reg;
        step_next      = step_reg;
        slot_next      = slot_reg;
        clr_next       = clr_reg;
        fwd_valid_next = 1'b0;
        fwd_data_next  = fwd_data_reg;
        fin_next       = fin_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        mem_we         = 1'b0;
        mem_waddr      = slot_reg;
        mem_wdata      = walk_word;
        mem_raddr      = slot_calc;
        s_tready       = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    sample_next = s_tdata;
                    slot_next   = slot_calc;
                    step_next   = '0;
                    state_next  = ST_WALK;
                end
            end
            ST_WALK:
            begin
                mem_we        = 1'b1;
                acc_next      = walk_acc;
                pos_next      = pos_inc;
                step_next     = step_reg + 1'b1;
                fwd_data_next = walk_word;
                if (step_reg == LAST_STEP)
                begin
                    mem_raddr      = pos_inc;
                    slot_next      = pos_inc;
                    fwd_valid_next = (pos_inc == slot_reg);
                    state_next     = ST_FOLD;
                end
                else
                begin
                    slot_next      = slot_calc;
                    fwd_valid_next = (slot_calc == slot_reg);
                end
            end
            ST_FOLD:
            begin
                mem_we     = 1'b1;
                mem_wdata  = rd_word ^ fold_acc;
                acc_next   = fold_acc;
                fin_next   = fin_word[OUT_W-1:0];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next       = fin_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            acc_reg       <= '0;
            pos_reg       <= '0;
            step_reg      <= '0;
            clr_reg       <= '0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            pos_reg       <= pos_next;
            step_reg      <= step_next;
            clr_reg       <= clr_next;
            fwd_valid_reg <= fwd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        slot_reg     <= slot_next;
        fwd_data_reg <= fwd_data_next;
        fin_reg      <= fin_next;
        out_reg      <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

FILE: hw/rtl/epm_pool_ram.sv
// Pool memory: one write port and one registered read port.
module epm_pool_ram #(
    parameter int DEPTH = epm_pkg::DEF_POOL_WORDS
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  epm_pkg::word_t           wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output epm_pkg::word_t           rdata
);
    import epm_pkg::*;

    word_t mem [DEPTH];
    word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
